### hdl/b32kc_pkg.sv
package b32kc_pkg;

  // One input beat: raw key character plus end-of-key flag
  typedef struct packed {
    logic [7:0] character;
    logic       is_final;
  } b32kc_in_t;

  // One result beat: data byte or closing status
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       status;
    logic       last;
  } b32kc_out_t;

  // Results produced by one character, in delivery order
  typedef struct packed {
    logic [1:0] count;
    b32kc_out_t first;
    b32kc_out_t second;
  } b32kc_res_t;

  // Symbol lookup outcome
  typedef struct packed {
    logic       valid;
    logic       pad;
    logic [4:0] value;
  } b32kc_sym_t;

  localparam logic       KIND_DATA   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic       STATUS_OK   = 1'b0;
  localparam logic       STATUS_BAD  = 1'b1;
  localparam logic [1:0] RES_MAX     = 2'd2;

  // Lenient base32 alphabet: either case, 2..7, and 0/1/8 read as O/L/B
  function automatic b32kc_sym_t sym_of(input logic [7:0] c);
    b32kc_sym_t s;
    s = '{valid: 1'b0, pad: 1'b0, value: 5'd0};
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.valid = 1'b1;
      s.value = 5'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.valid = 1'b1;
      s.value = 5'(c - 8'h61);
    end else if (c >= 8'h32 && c <= 8'h37) begin
      s.valid = 1'b1;
      s.value = 5'(c - 8'h32 + 8'd26);
    end else if (c == 8'h30) begin
      s.valid = 1'b1;
      s.value = 5'd14;
    end else if (c == 8'h31) begin
      s.valid = 1'b1;
      s.value = 5'd11;
    end else if (c == 8'h38) begin
      s.valid = 1'b1;
      s.value = 5'd1;
    end else if (c == 8'h3D) begin
      s.pad = 1'b1;
    end
    return s;
  endfunction

endpackage

### hdl/b32kc_core.sv
module b32kc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  b32kc_pkg::b32kc_in_t item,
  input  logic                 advance,
  output b32kc_pkg::b32kc_res_t res
);
  import b32kc_pkg::*;

  logic [2:0] pos_r, pos_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       pad_r, pad_nxt;
  logic       err_r, err_nxt;

  b32kc_sym_t  sym;
  logic [12:0] joined;
  logic [12:0] shifted;
  logic        emit;
  logic [1:0]  shamt;
  logic        bad;
  b32kc_out_t  data_res;
  b32kc_out_t  stat_res;

  // Decode the character and work out the next group state
  always_comb begin
    sym      = sym_of(item.character);
    joined   = {hold_r, sym.value};
    pos_nxt  = pos_r + 3'd1;
    hold_nxt = hold_r;
    pad_nxt  = pad_r;
    err_nxt  = err_r;
    emit     = 1'b0;
    shamt    = 2'd0;

    // Byte boundary: groups positions 1,3,4,6,7 settle a byte
    case (pos_r)
      3'd1: begin emit = 1'b1; shamt = 2'd2; end
      3'd3: begin emit = 1'b1; shamt = 2'd0; end
      3'd4: begin emit = 1'b1; shamt = 2'd1; end
      3'd6: begin emit = 1'b1; shamt = 2'd3; end
      3'd7: begin emit = 1'b1; shamt = 2'd0; end
      default: begin emit = 1'b0; shamt = 2'd0; end
    endcase

    if (!sym.valid && !sym.pad) begin
      err_nxt = 1'b1;
      emit    = 1'b0;
    end else if (sym.pad) begin
      if (pos_r == 3'd0) begin
        err_nxt = 1'b1;
      end else if (!pad_r && !(pos_r == 3'd2 || pos_r == 3'd4 ||
                               pos_r == 3'd5 || pos_r == 3'd7)) begin
        err_nxt = 1'b1;
      end
      pad_nxt = 1'b1;
      emit    = 1'b0;
    end else if (pad_r) begin
      err_nxt = 1'b1;
      emit    = 1'b0;
    end else begin
      hold_nxt = joined[7:0];
      emit     = emit && !err_r;
    end

    // Position 3 settles its byte at shift 4
    if (pos_r == 3'd3) begin
      shifted = joined >> 4;
    end else begin
      shifted = joined >> shamt;
    end

    bad = err_nxt || (pos_nxt != 3'd0);

    data_res = '{kind: KIND_DATA, data_byte: shifted[7:0], status: STATUS_OK,
                 last: 1'b0};
    stat_res = '{kind: KIND_STATUS, data_byte: 8'd0,
                 status: bad ? STATUS_BAD : STATUS_OK, last: 1'b1};

    res.count  = 2'(emit) + 2'(item.is_final);
    res.first  = emit ? data_res : stat_res;
    res.second = stat_res;
  end

  // Advance group state; end of key drops everything back to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 3'd0;
      hold_r <= 8'd0;
      pad_r  <= 1'b0;
      err_r  <= 1'b0;
    end else if (advance) begin
      if (item.is_final) begin
        pos_r  <= 3'd0;
        hold_r <= 8'd0;
        pad_r  <= 1'b0;
        err_r  <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        hold_r <= hold_nxt;
        pad_r  <= pad_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.is_final |-> res.count != 2'd0)
    else $error("final character produced no status");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.is_final |=> pos_r == 3'd0 && !pad_r && !err_r)
    else $error("state not cleared after end of key");

  a_advance_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> item_valid)
    else $error("advance without a held character");

endmodule

### hdl/b32kc_obuf.sv
module b32kc_obuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b32kc_pkg::b32kc_res_t res,
  input  logic                  out_stall,
  output logic                  out_valid,
  output b32kc_pkg::b32kc_out_t out_data,
  output logic [1:0]            free
);
  import b32kc_pkg::*;

  b32kc_out_t slot0_r, slot0_nxt;
  b32kc_out_t slot1_r, slot1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] remc;
  logic [1:0] pushc;
  b32kc_out_t rem0;

  // Pop the head, then append the new results behind what remains
  always_comb begin
    pop   = (cnt_r != 2'd0) && !out_stall;
    remc  = cnt_r - 2'(pop);
    pushc = push ? res.count : 2'd0;
    rem0  = pop ? slot1_r : slot0_r;
    free  = RES_MAX - cnt_r + 2'(pop);

    cnt_nxt   = remc + pushc;
    slot0_nxt = (remc != 2'd0) ? rem0 : res.first;
    case (remc)
      2'd2:    slot1_nxt = slot1_r;
      2'd1:    slot1_nxt = res.first;
      default: slot1_nxt = res.second;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_MAX && !(push && (res.count > free)))
    else $error("result buffer overflow");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.kind == KIND_STATUS)
    else $error("last beat is not a status");

endmodule

### hdl/base32_key_check_decode.sv
// Channel | Ports                            | Beat
// --------+----------------------------------+--------------------------------
// input   | in_valid, in_stall, in_data      | character, is_final
// result  | out_valid, out_stall, out_data   | kind, data_byte, status, last
//
// One character per cycle unless stalled: input register -> decode/pack -> 2-entry
// result buffer. A character gives at most one data byte; the final one adds a
// status beat, so a key ending on a byte boundary gives two result beats at the end.
// An accepted character passes the input register, then the result buffer.
// rst_n is synchronous and clears group state and both buffers.
// A stalled result side fills the buffer, then holds the input register.
module base32_key_check_decode (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  b32kc_pkg::b32kc_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output b32kc_pkg::b32kc_out_t out_data
);
  import b32kc_pkg::*;

  b32kc_in_t  item_r;
  logic       item_v_r;
  b32kc_res_t res;
  logic [1:0] free;
  logic       advance;
  logic       accept;

  // Move the held character on when the buffer has room for its results
  assign advance  = item_v_r && (res.count <= free);
  assign in_stall = item_v_r && !advance;
  assign accept   = in_valid && !in_stall;

  // Hold the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (accept) begin
      item_v_r <= 1'b1;
    end else if (advance) begin
      item_v_r <= 1'b0;
    end
    if (accept) begin
      item_r <= in_data;
    end
  end

  b32kc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_v_r),
    .item       (item_r),
    .advance    (advance),
    .res        (res)
  );

  b32kc_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (free)
  );

endmodule
